### sv/hsl_to_rgb_converter_macros.svh
// Assertion helpers shared by the converter modules.
`ifndef HSL_TO_RGB_CONVERTER_MACROS_SVH
`define HSL_TO_RGB_CONVERTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define H2R_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define H2R_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/h2r_pkg.sv
`default_nettype none

package h2r_pkg;

	localparam int NSTG = 8;

	localparam int ST_FRAC_A = 0;
	localparam int ST_FRAC_B = 1;
	localparam int ST_MUL    = 2;
	localparam int ST_LVL    = 3;
	localparam int ST_SEG    = 4;
	localparam int ST_PROD   = 5;
	localparam int ST_MIX    = 6;
	localparam int ST_OUT    = 7;

	typedef struct packed {
		logic [NSTG-1:0] en;
		logic [NSTG-1:0] vld;
	} stg_t;

	typedef enum logic [1:0] {
		SEG_RISE,
		SEG_HIGH,
		SEG_FALL,
		SEG_LOW
	} seg_t;

endpackage

`default_nettype wire

### sv/hsl_to_rgb_converter.sv
// Channel   Role    Beat contents (tdata, lowest bits first)
// s_axis    input   hue[15:0], saturation[31:16], lightness[47:32]
// m_axis    output  red[7:0], green[15:8], blue[23:16]
//
// One beat is accepted per cycle unless every stage is full and m_axis stalls.
// The eight-stage pipeline (fraction scaling, helper levels, one multiplier per
// channel) lies between input and output, and each stage holds one beat.
// Reset clears only the stage valid bits; the data registers are not reset.
// A stall on m_axis holds the output beat and lets empty stages fill up, so input
// is still taken while any stage is empty.
`default_nettype none

module hsl_to_rgb_converter #(
	parameter int FRAC_BITS = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [47:0] s_axis_tdata,  // hue, saturation, lightness
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata   // red, green, blue
);

	h2r_pkg::stg_t           stg;
	logic [2:0][15:0]        x;
	logic [2:0][FRAC_BITS:0] frac;
	logic                    grey_f;
	logic [2:0][FRAC_BITS:0] hue_pos;
	logic [FRAC_BITS:0]      hi;
	logic [FRAC_BITS:0]      lo;
	logic [FRAC_BITS:0]      lum;
	logic                    grey_l;
	logic [2:0][7:0]         rgb;

	assign x[0] = s_axis_tdata[15:0];
	assign x[1] = s_axis_tdata[31:16];
	assign x[2] = s_axis_tdata[47:32];

	h2r_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.stg       (stg)
	);

	h2r_frac #(.FRAC_BITS(FRAC_BITS)) u_frac (
		.clk  (clk),
		.stg  (stg),
		.x    (x),
		.frac (frac),
		.grey (grey_f)
	);

	h2r_levels #(.FRAC_BITS(FRAC_BITS)) u_levels (
		.clk     (clk),
		.stg     (stg),
		.frac    (frac),
		.grey_in (grey_f),
		.hue_pos (hue_pos),
		.hi      (hi),
		.lo      (lo),
		.lum     (lum),
		.grey    (grey_l)
	);

	for (genvar c = 0; c < 3; c++) begin : g_chan
		h2r_channel #(.FRAC_BITS(FRAC_BITS)) u_chan (
			.clk    (clk),
			.arst_n (arst_n),
			.stg    (stg),
			.hue    (hue_pos[c]),
			.hi     (hi),
			.lo     (lo),
			.lum    (lum),
			.grey   (grey_l),
			.chan   (rgb[c])
		);
	end

	assign m_axis_tdata = {rgb[2], rgb[1], rgb[0]};

endmodule

`default_nettype wire

### sv/h2r_ctl.sv
`default_nettype none
`include "hsl_to_rgb_converter_macros.svh"

module h2r_ctl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic         out_ready,
	output logic              out_valid,
	output h2r_pkg::stg_t     stg
);

	logic [h2r_pkg::NSTG-1:0] vld_q;
	logic [h2r_pkg::NSTG-1:0] en;

	// A stage may load when it is empty or when the stage after it moves on.
	always_comb begin
		en[h2r_pkg::NSTG-1] = !vld_q[h2r_pkg::NSTG-1] || out_ready;
		for (int k = h2r_pkg::NSTG - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < h2r_pkg::NSTG; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_q[h2r_pkg::NSTG-1];
	assign stg       = {en, vld_q};

	`H2R_ASSERT_NOW(a_bubble_ready, clk, arst_n, !vld_q[h2r_pkg::NSTG-1], in_ready, "input stalled with an empty output stage")
	`H2R_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "output beat dropped while stalled")
	`H2R_ASSERT_NEXT(a_in_capture, clk, arst_n, in_valid && in_ready, vld_q[h2r_pkg::ST_FRAC_A], "accepted beat not captured")

endmodule

`default_nettype wire

### sv/h2r_frac.sv
`default_nettype none

module h2r_frac #(
	parameter int FRAC_BITS = 24
) (
	input  wire logic                      clk,
	input  wire h2r_pkg::stg_t             stg,
	input  wire logic [2:0][15:0]          x,
	output logic [2:0][FRAC_BITS:0]        frac,
	output logic                           grey
);

	localparam int WA = 16 + FRAC_BITS;

	logic [2:0][WA-1:0]      a_w;
	logic [2:0][WA:0]        sum_w;
	logic [2:0][FRAC_BITS:0] q0_w;
	logic [2:0][16:0]        alo_w;
	logic [2:0][16:0]        r_w;
	logic [2:0][FRAC_BITS:0] q_w;

	logic [2:0][15:0]        x_s1;
	logic [2:0][FRAC_BITS:0] q0_s1;
	logic                    grey_s1;
	logic [2:0][FRAC_BITS:0] q_s2;
	logic                    grey_s2;

	// x * 2^F / 65535 is estimated from the series 2^-16 + 2^-32 + ..., which
	// lands on the exact quotient or one below it; the remainder fixes that.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			a_w[i]   = {x[i], {FRAC_BITS{1'b0}}};
			sum_w[i] = {1'b0, a_w[i]} + (WA+1)'(a_w[i] >> 16) + (WA+1)'(a_w[i] >> 32);
			q0_w[i]  = sum_w[i][WA:16];
		end
	end

	always_ff @(posedge clk) begin
		if (stg.en[h2r_pkg::ST_FRAC_A]) begin
			x_s1    <= x;
			q0_s1   <= q0_w;
			grey_s1 <= (x[1] == 16'd0);
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			alo_w[i] = 17'({x_s1[i], {FRAC_BITS{1'b0}}});
			r_w[i]   = alo_w[i] - {q0_s1[i][0], 16'd0} + q0_s1[i][16:0];
			q_w[i]   = q0_s1[i] + (FRAC_BITS+1)'(r_w[i] >= 17'd65535);
		end
	end

	always_ff @(posedge clk) begin
		if (stg.en[h2r_pkg::ST_FRAC_B]) begin
			q_s2    <= q_w;
			grey_s2 <= grey_s1;
		end
	end

	assign frac = q_s2;
	assign grey = grey_s2;

endmodule

`default_nettype wire

### sv/h2r_levels.sv
`default_nettype none

module h2r_levels #(
	parameter int FRAC_BITS = 24
) (
	input  wire logic                      clk,
	input  wire h2r_pkg::stg_t             stg,
	input  wire logic [2:0][FRAC_BITS:0]   frac,
	input  wire logic                      grey_in,
	output logic [2:0][FRAC_BITS:0]        hue_pos,
	output logic [FRAC_BITS:0]             hi,
	output logic [FRAC_BITS:0]             lo,
	output logic [FRAC_BITS:0]             lum,
	output logic                           grey
);

	localparam int F = FRAC_BITS;
	localparam logic [F:0] ONE         = {1'b1, {F{1'b0}}};
	localparam logic [F:0] THIRD       = (F+1)'(ONE / 3);
	localparam logic [F:0] ONE_M_THIRD = ONE - THIRD;

	logic [F+1:0]       hp_sum_w;
	logic [F:0]         hp_w;
	logic [F:0]         hm_w;

	logic [2*F+1:0]     prod_s3;
	logic [2:0][F:0]    hue_s3;
	logic [F:0]         lum_s3;
	logic [F:0]         sat_s3;
	logic               grey_s3;

	logic [F:0]         p_w;
	logic [F+1:0]       hi_w;
	logic [F+1:0]       two_l_w;
	logic [F:0]         lo_w;

	logic [2:0][F:0]    hue_s4;
	logic [F:0]         hi_s4;
	logic [F:0]         lo_s4;
	logic [F:0]         lum_s4;
	logic               grey_s4;

	always_comb begin
		hp_sum_w = {1'b0, frac[0]} + {1'b0, THIRD};
		hp_w     = (hp_sum_w > {1'b0, ONE}) ? (F+1)'(hp_sum_w - {1'b0, ONE}) : (F+1)'(hp_sum_w);
		hm_w     = (frac[0] >= THIRD) ? (frac[0] - THIRD) : (frac[0] + ONE_M_THIRD);
	end

	always_ff @(posedge clk) begin
		if (stg.en[h2r_pkg::ST_MUL]) begin
			prod_s3   <= (2*F+2)'(frac[2]) * (2*F+2)'(frac[1]);
			hue_s3[0] <= hp_w;
			hue_s3[1] <= frac[0];
			hue_s3[2] <= hm_w;
			lum_s3    <= frac[2];
			sat_s3    <= frac[1];
			grey_s3   <= grey_in;
		end
	end

	// Below one half the high level is L + L*S, otherwise L + S - L*S.
	always_comb begin
		p_w     = (F+1)'(prod_s3 >> F);
		hi_w    = (lum_s3[F:F-1] == 2'b00) ? ({1'b0, lum_s3} + {1'b0, p_w})
		                                   : ({1'b0, lum_s3} + {1'b0, sat_s3} - {1'b0, p_w});
		two_l_w = {lum_s3, 1'b0};
		lo_w    = (two_l_w >= hi_w) ? (F+1)'(two_l_w - hi_w) : '0;
	end

	always_ff @(posedge clk) begin
		if (stg.en[h2r_pkg::ST_LVL]) begin
			hue_s4  <= hue_s3;
			hi_s4   <= (F+1)'(hi_w);
			lo_s4   <= lo_w;
			lum_s4  <= lum_s3;
			grey_s4 <= grey_s3;
		end
	end

	assign hue_pos = hue_s4;
	assign hi      = hi_s4;
	assign lo      = lo_s4;
	assign lum     = lum_s4;
	assign grey    = grey_s4;

endmodule

`default_nettype wire

### sv/h2r_channel.sv
`default_nettype none
`include "hsl_to_rgb_converter_macros.svh"

module h2r_channel #(
	parameter int FRAC_BITS = 24
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire h2r_pkg::stg_t         stg,
	input  wire logic [FRAC_BITS:0]    hue,
	input  wire logic [FRAC_BITS:0]    hi,
	input  wire logic [FRAC_BITS:0]    lo,
	input  wire logic [FRAC_BITS:0]    lum,
	input  wire logic                  grey,
	output logic [7:0]                 chan
);

	localparam int F = FRAC_BITS;
	localparam logic [F:0]   ONE      = {1'b1, {F{1'b0}}};
	localparam logic [F+3:0] ONE_W    = {3'b000, ONE};
	localparam logic [F+3:0] FOUR_ONE = {2'b01, {(F+2){1'b0}}};

	logic [F+3:0]       six_w;
	logic [F+2:0]       three_w;
	h2r_pkg::seg_t      seg_w;
	logic [F:0]         d_w;

	h2r_pkg::seg_t      seg_s5;
	logic [F:0]         arg_s5;
	logic [F:0]         d_s5;
	logic [F:0]         lo_s5;
	logic [F:0]         hi_s5;
	logic [F:0]         lum_s5;
	logic               grey_s5;

	h2r_pkg::seg_t      seg_s6;
	logic [2*F+1:0]     prod_s6;
	logic [F:0]         lo_s6;
	logic [F:0]         hi_s6;
	logic [F:0]         lum_s6;
	logic               grey_s6;

	logic [F+1:0]       ramp_w;
	logic [F:0]         level_w;
	logic [F:0]         level_s7;

	logic [F+8:0]       scaled_w;
	logic [8:0]         cw_w;
	logic [7:0]         chan_s8;

	always_comb begin
		six_w   = ({3'b000, hue} << 2) + ({3'b000, hue} << 1);
		three_w = {1'b0, hue, 1'b0} + {2'b00, hue};
		if (six_w < ONE_W) begin
			seg_w = h2r_pkg::SEG_RISE;
		end else if ({hue, 1'b0} < {1'b0, ONE}) begin
			seg_w = h2r_pkg::SEG_HIGH;
		end else if (three_w < {1'b0, ONE, 1'b0}) begin
			seg_w = h2r_pkg::SEG_FALL;
		end else begin
			seg_w = h2r_pkg::SEG_LOW;
		end
		d_w = (hi >= lo) ? (hi - lo) : '0;
	end

	always_ff @(posedge clk) begin
		if (stg.en[h2r_pkg::ST_SEG]) begin
			seg_s5  <= seg_w;
			arg_s5  <= (seg_w == h2r_pkg::SEG_RISE) ? (F+1)'(six_w) : (F+1)'(FOUR_ONE - six_w);
			d_s5    <= d_w;
			lo_s5   <= lo;
			hi_s5   <= hi;
			lum_s5  <= lum;
			grey_s5 <= grey;
		end
	end

	always_ff @(posedge clk) begin
		if (stg.en[h2r_pkg::ST_PROD]) begin
			seg_s6  <= seg_s5;
			prod_s6 <= (2*F+2)'(d_s5) * (2*F+2)'(arg_s5);
			lo_s6   <= lo_s5;
			hi_s6   <= hi_s5;
			lum_s6  <= lum_s5;
			grey_s6 <= grey_s5;
		end
	end

	always_comb begin
		ramp_w = {1'b0, lo_s6} + (F+2)'(prod_s6 >> F);
		case (seg_s6)
			h2r_pkg::SEG_RISE: level_w = (F+1)'(ramp_w);
			h2r_pkg::SEG_FALL: level_w = (F+1)'(ramp_w);
			h2r_pkg::SEG_HIGH: level_w = hi_s6;
			h2r_pkg::SEG_LOW:  level_w = lo_s6;
			default:           level_w = lo_s6;
		endcase
		if (grey_s6) begin
			level_w = lum_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (stg.en[h2r_pkg::ST_MIX]) begin
			level_s7 <= level_w;
		end
	end

	always_comb begin
		scaled_w = {level_s7, 8'd0} - {8'd0, level_s7};
		cw_w     = scaled_w[F+8:F];
	end

	always_ff @(posedge clk) begin
		if (stg.en[h2r_pkg::ST_OUT]) begin
			chan_s8 <= (cw_w > 9'd255) ? 8'hFF : cw_w[7:0];
		end
	end

	assign chan = chan_s8;

	`H2R_ASSERT_NOW(a_level_range, clk, arst_n, stg.vld[h2r_pkg::ST_MIX], level_s7 <= ONE, "level above full scale")
	`H2R_ASSERT_NOW(a_rise_arg, clk, arst_n, stg.vld[h2r_pkg::ST_SEG] && (seg_s5 == h2r_pkg::SEG_RISE), arg_s5 < ONE, "rising ramp argument out of range")

endmodule

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int      FRAC       = 24;
	localparam longint  ONE        = longint'(1) << FRAC;
	localparam longint  THIRD      = ONE / 3;
	localparam int      TIME_LIMIT = 200000;
	localparam int      DRAIN_WAIT = 24;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;    // hue[15:0], saturation[31:16], lightness[47:32]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;         // red[7:0], green[15:8], blue[23:16]

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int cycles = 0;

	hsl_to_rgb_converter #(.FRAC_BITS(FRAC)) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	class pixel_scoreboard;
		logic [23:0] want_rgb[$];
		int          failures = 0;

		function longint frac_of(logic [15:0] x);
			return (longint'(x) << FRAC) / 65535;
		endfunction

		function longint mul_frac(longint a, longint b);
			logic [127:0] p;
			p = {64'd0, a} * {64'd0, b};
			return longint'(p >> FRAC);
		endfunction

		function logic [7:0] channel_of(longint level);
			longint c;
			c = (255 * level) >>> FRAC;
			return (c > 255) ? 8'd255 : c[7:0];
		endfunction

		function longint level_at(longint lo, longint hi, longint h);
			longint d;
			d = (hi >= lo) ? hi - lo : 0;
			if (h < 0)
				h += ONE;
			if (h > ONE)
				h -= ONE;
			if (h < 0)
				h = 0;
			if (6 * h < ONE)
				return lo + mul_frac(d, 6 * h);
			if (2 * h < ONE)
				return hi;
			if (3 * h < 2 * ONE)
				return lo + mul_frac(d, 4 * ONE - 6 * h);
			return lo;
		endfunction

		function logic [23:0] rgb_of(logic [47:0] hsl);
			longint     h, s, l, hi, lo;
			logic [7:0] grey;
			h = frac_of(hsl[15:0]);
			s = frac_of(hsl[31:16]);
			l = frac_of(hsl[47:32]);
			if (hsl[31:16] == 16'd0) begin
				grey = channel_of(l);
				return {grey, grey, grey};
			end
			if (2 * l < ONE)
				hi = mul_frac(l, ONE + s);
			else
				hi = (l + s) - mul_frac(s, l);
			lo = (2 * l >= hi) ? 2 * l - hi : 0;
			return {channel_of(level_at(lo, hi, h - THIRD)),
				channel_of(level_at(lo, hi, h)),
				channel_of(level_at(lo, hi, h + THIRD))};
		endfunction

		function void note_pixel(logic [47:0] hsl);
			want_rgb.push_back(rgb_of(hsl));
		endfunction

		function void check_pixel(logic [23:0] rgb);
			logic [23:0] want;
			if (want_rgb.size() == 0) begin
				$error("unexpected result beat %h", rgb);
				failures++;
				return;
			end
			want = want_rgb.pop_front();
			if (rgb[7:0] !== want[7:0]) begin
				$error("red: expected %0d, got %0d", want[7:0], rgb[7:0]);
				failures++;
			end
			if (rgb[15:8] !== want[15:8]) begin
				$error("green: expected %0d, got %0d", want[15:8], rgb[15:8]);
				failures++;
			end
			if (rgb[23:16] !== want[23:16]) begin
				$error("blue: expected %0d, got %0d", want[23:16], rgb[23:16]);
				failures++;
			end
		endfunction

		function int pending();
			return want_rgb.size();
		endfunction
	endclass

	pixel_scoreboard board = new();

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > TIME_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				board.check_pixel(m_axis_tdata);
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_pixel(input logic [15:0] hue, input logic [15:0] sat,
			input logic [15:0] light);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {light, sat, hue};
		do
			@(posedge clk);
		while (!s_axis_tready);
		board.note_pixel({light, sat, hue});
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [15:0] pick_field();
		case ($urandom_range(9))
			0: return 16'd0;
			1: return 16'd65535;
			2: return 16'd32767;
			3: return 16'd32768;
			4: return 16'd21845 + 16'($urandom_range(2));
			5: return 16'd43690 + 16'($urandom_range(2));
			6: return 16'd10922 + 16'($urandom_range(2));
			7: return 16'd54612 + 16'($urandom_range(2));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_random(input int count);
		logic [15:0] h, s, l;
		for (int i = 0; i < count; i++) begin
			h = 16'($urandom);
			s = 16'($urandom);
			l = 16'($urandom);
			case ($urandom_range(9))
				0: s = 16'd0;
				1, 2: begin
					h = pick_field();
					s = pick_field();
					l = pick_field();
				end
				default: ;
			endcase
			send_pixel(h, s, l);
		end
	endtask

	initial begin
		logic [47:0] corner[$];
		corner = '{
			{16'd0,     16'd0,     16'd0},
			{16'd65535, 16'd65535, 16'd65535},
			{16'd65535, 16'd0,     16'd12345},
			{16'd40000, 16'd0,     16'd0},
			{16'd32767, 16'd65535, 16'd0},
			{16'd32768, 16'd65535, 16'd0},
			{16'd32767, 16'd65535, 16'd21845},
			{16'd32768, 16'd65535, 16'd43690},
			{16'd32768, 16'd65535, 16'd65535},
			{16'd32768, 16'd1,     16'd0},
			{16'd32768, 16'd65535, 16'd10922},
			{16'd32768, 16'd65535, 16'd10923},
			{16'd32768, 16'd65535, 16'd54612},
			{16'd32768, 16'd65535, 16'd54613},
			{16'd20000, 16'd40000, 16'd5000},
			{16'd50000, 16'd30000, 16'd60000},
			{16'd65535, 16'd65535, 16'd32768},
			{16'd0,     16'd65535, 16'd65535},
			{16'd43690, 16'd12345, 16'd65535},
			{16'd21845, 16'd43690, 16'd32767}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 15;
		recv_stall_pct = 56;
		foreach (corner[i])
			send_pixel(corner[i][15:0], corner[i][31:16], corner[i][47:32]);
		send_random(60);
		wait_drained();
		send_random(70);
		wait_drained();

		send_idle_pct = 56;
		recv_stall_pct = 15;
		send_random(135);
		wait_drained();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_random(135);
		wait_drained();

		repeat (DRAIN_WAIT) @(posedge clk);
		if (board.failures == 0 && board.pending() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
